// ===== hdl/snd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package snd_pkg;

  localparam int TABLE_BITS = 8;
  localparam int GRAD_COUNT = 8;
  localparam int GRAD_BITS  = $clog2(GRAD_COUNT);

  typedef logic [TABLE_BITS-1:0] tidx_t;
  typedef logic [7:0]            tval_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // skew and unskew factors: F2 in Q.30, G2 in Q.32
  localparam logic signed [30:0] SKEW_F2   = 31'sd393016785;
  localparam logic signed [30:0] UNSKEW_G2 = 31'sd907633387;
  localparam logic [39:0]        G2_Q32    = 40'd907633387;
  localparam logic [39:0]        ONE_Q32   = 40'h01_0000_0000;
  localparam logic signed [35:0] OFS_LIMIT = 36'sd536870912;
  localparam logic signed [61:0] HALF_Q56  = 62'sd36028797018963968;

  // gradient dot product for the eight standard directions
  function automatic logic signed [31:0] grad_dot(input logic [2:0] g,
                                                  input logic signed [30:0] dx,
                                                  input logic signed [30:0] dy);
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    ex = 32'(dx);
    ey = 32'(dy);
    case (g)
      3'd0:    grad_dot = ex + ey;
      3'd1:    grad_dot = ey - ex;
      3'd2:    grad_dot = ex - ey;
      3'd3:    grad_dot = -ex - ey;
      3'd4:    grad_dot = ex;
      3'd5:    grad_dot = -ex;
      3'd6:    grad_dot = ey;
      3'd7:    grad_dot = -ey;
      default: grad_dot = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/simplex_noise_2d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                   | accepted when
// --------+-------------------------------------------+------------------------
// in      | op table_index table_value coord_x coord_y | in_valid && in_ready
// out     | noise_value                               | out_valid && out_ready
//
// Twelve register stages, one request per cycle unless a stall backs up to the input;
// a load writes the inner hash copies as it enters stage 3 and the outer copies as it
// enters stage 4, in request order.
// Reset clears only the stage valid bits; the permutation copies are not cleared.
// A stage holds while the one after it is full and stalled; bubbles collapse, so
// requests keep entering while a result waits at the output.

module simplex_noise_2d_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire snd_pkg::op_t           op,
  input  wire logic [7:0]             table_index,
  input  wire logic [7:0]             table_value,
  input  wire logic signed [31:0]     coord_x,
  input  wire logic signed [31:0]     coord_y,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [15:0]          noise_value
);

  import snd_pkg::*;

  localparam int NSTAGE = 12;
  localparam int DROP_LOADS = 5;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  // ---- stage 0: input capture
  op_t                s0_op;
  tidx_t              s0_idx;
  tval_t              s0_val;
  logic signed [31:0] s0_x, s0_y;

  // ---- stage 1: skew product
  op_t                s1_op;
  tidx_t              s1_idx;
  tval_t              s1_val;
  logic signed [31:0] s1_x, s1_y;
  logic signed [62:0] s1_sum;
  logic signed [32:0] sxy;

  // ---- stage 2: cell
  op_t                s2_op;
  tidx_t              s2_idx;
  tval_t              s2_val;
  logic signed [31:0] s2_x, s2_y;
  logic signed [17:0] s2_ci, s2_cj;
  logic signed [63:0] skx, sky;

  // ---- stage 3: unskew product, inner hash reads
  op_t                s3_op;
  tidx_t              s3_idx;
  tval_t              s3_val;
  logic signed [31:0] s3_x, s3_y;
  logic signed [17:0] s3_ci, s3_cj;
  logic [39:0]        s3_prod;
  logic signed [18:0] cell_sum;
  logic signed [49:0] unskew;
  tval_t              p_lo, p_hi;
  logic               inner_we;

  // ---- stage 4: first offsets, outer hash reads
  op_t                s4_op;
  logic [39:0]        s4_x0, s4_y0;
  logic               s4_i1;
  logic [39:0]        x0_c, y0_c;
  logic               i1_c;
  tidx_t              oaddr [3];
  tval_t              hash [3];
  logic               outer_we;

  // ---- stage 5: corner offsets in Q.28
  logic signed [30:0] s5_dx [3];
  logic signed [30:0] s5_dy [3];
  logic [2:0]         s5_g [3];
  logic [39:0]        ofs_x [3];
  logic [39:0]        ofs_y [3];

  // ---- stage 6: falloff base and dot
  logic [29:0]        s6_t30 [3];
  logic               s6_live [3];
  logic signed [31:0] s6_dot [3];

  // ---- stage 7, 8: falloff powers
  logic [28:0]        s7_t2 [3];
  logic               s7_live [3];
  logic signed [31:0] s7_dot [3];
  logic [26:0]        s8_t4 [3];
  logic               s8_live [3];
  logic signed [31:0] s8_dot [3];

  // ---- stage 9: corner terms
  logic signed [58:0] s9_c [3];

  // ---- stage 10, 11: sum, scale, round
  logic signed [39:0] s10_scaled;
  logic signed [60:0] total;
  logic signed [39:0] floored;
  logic signed [39:0] rounded;
  logic signed [15:0] s11_noise;

  function automatic logic signed [30:0] to_q28(input logic [39:0] d32);
    logic signed [35:0] d;
    d = 36'($signed(d32) >>> 4);
    if (d > OFS_LIMIT) begin
      d = OFS_LIMIT;
    end else if (d < -OFS_LIMIT) begin
      d = -OFS_LIMIT;
    end
    to_q28 = 31'(d);
  endfunction

  // ---- flow control
  assign en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];
  assign noise_value = s11_noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          if (k == DROP_LOADS) begin
            v[k] <= v[k-1] && (s4_op == OP_EVAL);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // ---- stage 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_op  <= op;
      s0_idx <= tidx_t'(table_index);
      s0_val <= table_value;
      s0_x   <= coord_x;
      s0_y   <= coord_y;
    end
  end

  // ---- stage 1
  assign sxy = 33'(s0_x) + 33'(s0_y);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op  <= s0_op;
      s1_idx <= s0_idx;
      s1_val <= s0_val;
      s1_x   <= s0_x;
      s1_y   <= s0_y;
      s1_sum <= 63'(sxy) * 63'(SKEW_F2);
    end
  end

  // ---- stage 2
  assign skx = (64'(s1_x) <<< 30) + 64'(s1_sum);
  assign sky = (64'(s1_y) <<< 30) + 64'(s1_sum);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op  <= s1_op;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      s2_ci  <= skx[63:46];
      s2_cj  <= sky[63:46];
    end
  end

  // ---- stage 3
  assign cell_sum = 19'(s2_ci) + 19'(s2_cj);
  assign unskew   = 50'(cell_sum) * 50'(UNSKEW_G2);
  assign inner_we = en[3] && v[2] && (s2_op == OP_LOAD);

  snd_ram #(.ADDR_W(TABLE_BITS), .DATA_W(8)) u_inner_lo (
    .clk   (clk),
    .we    (inner_we),
    .waddr (s2_idx),
    .wdata (s2_val),
    .re    (en[3]),
    .raddr (s2_cj[TABLE_BITS-1:0]),
    .rdata (p_lo)
  );

  snd_ram #(.ADDR_W(TABLE_BITS), .DATA_W(8)) u_inner_hi (
    .clk   (clk),
    .we    (inner_we),
    .waddr (s2_idx),
    .wdata (s2_val),
    .re    (en[3]),
    .raddr (s2_cj[TABLE_BITS-1:0] + tidx_t'(1)),
    .rdata (p_hi)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_op   <= s2_op;
      s3_idx  <= s2_idx;
      s3_val  <= s2_val;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_ci   <= s2_ci;
      s3_cj   <= s2_cj;
      s3_prod <= unskew[39:0];
    end
  end

  // ---- stage 4: offsets kept modulo 2^40, true values are small
  assign x0_c = {s3_x[23:0], 16'b0} - {s3_ci[7:0], 32'b0} + s3_prod;
  assign y0_c = {s3_y[23:0], 16'b0} - {s3_cj[7:0], 32'b0} + s3_prod;
  assign i1_c = $signed(x0_c) > $signed(y0_c);

  // middle corner uses row cj when stepping in x, cj + 1 otherwise
  assign oaddr[0] = s3_ci[TABLE_BITS-1:0] + tidx_t'(p_lo);
  assign oaddr[1] = s3_ci[TABLE_BITS-1:0] + tidx_t'(i1_c) + tidx_t'(i1_c ? p_lo : p_hi);
  assign oaddr[2] = s3_ci[TABLE_BITS-1:0] + tidx_t'(1) + tidx_t'(p_hi);
  assign outer_we = en[4] && v[3] && (s3_op == OP_LOAD);

  for (genvar c = 0; c < 3; c++) begin : g_outer
    snd_ram #(.ADDR_W(TABLE_BITS), .DATA_W(8)) u_outer (
      .clk   (clk),
      .we    (outer_we),
      .waddr (s3_idx),
      .wdata (s3_val),
      .re    (en[4]),
      .raddr (oaddr[c]),
      .rdata (hash[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op <= s3_op;
      s4_x0 <= x0_c;
      s4_y0 <= y0_c;
      s4_i1 <= i1_c;
    end
  end

  // ---- stage 5
  assign ofs_x[0] = s4_x0;
  assign ofs_y[0] = s4_y0;
  assign ofs_x[1] = s4_x0 - (s4_i1 ? ONE_Q32 : '0) + G2_Q32;
  assign ofs_y[1] = s4_y0 - (s4_i1 ? '0 : ONE_Q32) + G2_Q32;
  assign ofs_x[2] = s4_x0 - ONE_Q32 + (G2_Q32 << 1);
  assign ofs_y[2] = s4_y0 - ONE_Q32 + (G2_Q32 << 1);

  always_ff @(posedge clk) begin
    logic [3:0] gi;
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        gi = 4'(hash[c][GRAD_BITS-1:0]);
        s5_dx[c] <= to_q28(ofs_x[c]);
        s5_dy[c] <= to_q28(ofs_y[c]);
        s5_g[c]  <= gi[2:0];
      end
    end
  end

  // ---- stage 6
  always_ff @(posedge clk) begin
    logic signed [61:0] t;
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        t = HALF_Q56 - 62'(s5_dx[c]) * 62'(s5_dx[c]) - 62'(s5_dy[c]) * 62'(s5_dy[c]);
        s6_live[c] <= !t[61];
        s6_t30[c]  <= t[55:26];
        s6_dot[c]  <= grad_dot(s5_g[c], s5_dx[c], s5_dy[c]);
      end
    end
  end

  // ---- stage 7
  always_ff @(posedge clk) begin
    logic [59:0] sq;
    if (en[7]) begin
      for (int c = 0; c < 3; c++) begin
        sq = 60'(s6_t30[c]) * 60'(s6_t30[c]);
        s7_t2[c]   <= sq[58:30];
        s7_live[c] <= s6_live[c];
        s7_dot[c]  <= s6_dot[c];
      end
    end
  end

  // ---- stage 8
  always_ff @(posedge clk) begin
    logic [57:0] sq;
    if (en[8]) begin
      for (int c = 0; c < 3; c++) begin
        sq = 58'(s7_t2[c]) * 58'(s7_t2[c]);
        s8_t4[c]   <= sq[56:30];
        s8_live[c] <= s7_live[c];
        s8_dot[c]  <= s7_dot[c];
      end
    end
  end

  // ---- stage 9
  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int c = 0; c < 3; c++) begin
        if (s8_live[c]) begin
          s9_c[c] <= 59'($signed({1'b0, s8_t4[c]})) * 59'(s8_dot[c]);
        end else begin
          s9_c[c] <= '0;
        end
      end
    end
  end

  // ---- stage 10
  assign total   = 61'(s9_c[0]) + 61'(s9_c[1]) + 61'(s9_c[2]);
  assign floored = 40'(total >>> 28);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_scaled <= floored * 40'sd70;
    end
  end

  // ---- stage 11: round half up to Q.15 and saturate
  assign rounded = (s10_scaled + 40'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      if (rounded > 40'sd32767) begin
        s11_noise <= 16'sh7fff;
      end else if (rounded < -40'sd32768) begin
        s11_noise <= 16'sh8000;
      end else begin
        s11_noise <= rounded[15:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/snd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module snd_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // read-before-write on a shared edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/snd_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module snd_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] noise_value
);

  // no result comes out of a pipeline that reset just emptied
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // the input side only backs up when every stage is full behind a stalled output
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(noise_value)))
    else $error("stalled result changed or dropped");

  // while the output drains, a new request is always taken
  a_accept_on_drain: assert property (@(posedge clk) disable iff (rst)
    (out_ready && in_valid) |-> in_ready)
    else $error("request refused while output drains");

endmodule

bind simplex_noise_2d_unit snd_check u_snd_check (.*);

`default_nettype wire
